/* rtl/core/ole_pkg.sv */
// ole_pkg: shared constants, command and status codes and the cell control bundle
// for the ordered list engine. Depends on nothing; used by every file in rtl/core.

package ole_pkg;

    // sizes of the list and of the fields
    localparam int CAPACITY   = 16;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int COUNT_W    = 5;
    localparam int OP_W       = 3;
    localparam int POS_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int IN_TDATA_W = 40;
    localparam int OUT_TDATA_W = 40;

    // command codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT     = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;
    localparam logic [OP_W-1:0] OP_READ       = 3'd6;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd7;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    // what every cell sees for the current request
    typedef struct packed {
        logic               ins_en;
        logic               rem_en;
        logic [IDX_W-1:0]   slot;
        logic [DATA_W-1:0]  value;
        logic [COUNT_W-1:0] count;
    } cell_ctrl_t;

endpackage

/* rtl/core/ordered_list_engine.sv */
// ordered_list_engine: an accepted request has its result registered in the output
// register in the next cycle; one request per cycle is taken while s_tready is high,
// because every cell of the chain shifts, compares or is read in parallel.
// A result waiting in the output register does not stop the next request while
// the sink takes it. aresetn (synchronous, active low) empties the list and the
// output register; cell contents are left as they are and never read unwritten.

module ordered_list_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // op [2:0], position [7:3], value [39:8]
    input  logic [ole_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [1:0], read_value [33:2], found [34], count [39:35]
    output logic [ole_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    logic [ole_pkg::OP_W-1:0]     op;
    logic [ole_pkg::POS_W-1:0]    position;
    logic [ole_pkg::DATA_W-1:0]   value;
    logic                         accept;
    logic                         full;
    logic                         empty;
    logic                         ins_ok;
    logic                         rem_ok;
    logic                         rd_ok;
    logic                         pos_bad;
    logic [ole_pkg::IDX_W-1:0]    slot;
    logic [ole_pkg::STATUS_W-1:0] status;
    ole_pkg::cell_ctrl_t          ctrl;
    logic [ole_pkg::DATA_W-1:0]   read_data;
    logic                         any_match;

    logic [ole_pkg::COUNT_W-1:0]  count_reg;
    logic [ole_pkg::COUNT_W-1:0]  count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [ole_pkg::STATUS_W-1:0] status_reg;
    logic [31:0]                  read_value_reg;
    logic                         found_reg;
    logic [ole_pkg::COUNT_W-1:0]  out_count_reg;

    // request fields
    assign op       = s_tdata[2:0];
    assign position = s_tdata[7:3];
    assign value    = ole_pkg::DATA_W'(s_tdata[39:8]);

    // output register frees up when empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign full    = (count_reg == ole_pkg::COUNT_W'(ole_pkg::CAPACITY));
    assign empty   = (count_reg == '0);
    assign pos_bad = (position == '0) || (position > count_reg);

    // command decode: target slot, status and which way the chain moves
    always_comb begin
        ins_ok = 1'b0;
        rem_ok = 1'b0;
        rd_ok  = 1'b0;
        slot   = '0;
        status = ole_pkg::ST_DONE;
        case (op)
            ole_pkg::OP_PUSH_FRONT: begin
                if (full) status = ole_pkg::ST_FULL;
                else      ins_ok = 1'b1;
            end
            ole_pkg::OP_PUSH_BACK: begin
                slot = ole_pkg::IDX_W'(count_reg);
                if (full) status = ole_pkg::ST_FULL;
                else      ins_ok = 1'b1;
            end
            ole_pkg::OP_POP_FRONT: begin
                if (empty) status = ole_pkg::ST_EMPTY;
                else       rem_ok = 1'b1;
            end
            ole_pkg::OP_POP_BACK: begin
                slot = ole_pkg::IDX_W'(count_reg - 1'b1);
                if (empty) status = ole_pkg::ST_EMPTY;
                else       rem_ok = 1'b1;
            end
            ole_pkg::OP_INSERT: begin
                slot = ole_pkg::IDX_W'(position);
                if (position > count_reg) status = ole_pkg::ST_RANGE;
                else if (full)            status = ole_pkg::ST_FULL;
                else                      ins_ok = 1'b1;
            end
            ole_pkg::OP_REMOVE: begin
                slot = ole_pkg::IDX_W'(position - 1'b1);
                if (pos_bad) status = ole_pkg::ST_RANGE;
                else         rem_ok = 1'b1;
            end
            ole_pkg::OP_READ: begin
                slot = ole_pkg::IDX_W'(position - 1'b1);
                if (pos_bad) status = ole_pkg::ST_RANGE;
                else         rd_ok  = 1'b1;
            end
            default: begin
                status = ole_pkg::ST_DONE;
            end
        endcase
    end

    // broadcast to the cells
    always_comb begin
        ctrl.ins_en = accept && ins_ok;
        ctrl.rem_en = accept && rem_ok;
        ctrl.slot   = slot;
        ctrl.value  = value;
        ctrl.count  = count_reg;
    end

    ole_chain u_chain (
        .aclk      (aclk),
        .ctrl      (ctrl),
        .read_slot (slot),
        .read_data (read_data),
        .any_match (any_match)
    );

    // element count and output valid
    always_comb begin
        count_next = count_reg;
        if (ctrl.ins_en) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.rem_en) begin
            count_next = count_reg - 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (accept) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg     <= status;
            read_value_reg <= rd_ok ? 32'(read_data) : '0;
            found_reg      <= (op == ole_pkg::OP_FIND) && any_match;
            out_count_reg  <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_count_reg, found_reg, read_value_reg, status_reg};

`ifndef SYNTH
    // list never grows beyond its capacity
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= ole_pkg::COUNT_W'(ole_pkg::CAPACITY))
        else $error("list count above capacity");

    // a push onto a full list leaves the count alone
    a_full_push: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && full && (op == ole_pkg::OP_PUSH_FRONT || op == ole_pkg::OP_PUSH_BACK)
        |=> $stable(count_reg))
        else $error("push on full list changed count");

    // every accepted request leaves a result behind
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    // full status only ever reported with a full list
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (status_reg == ole_pkg::ST_FULL)
        |-> out_count_reg == ole_pkg::COUNT_W'(ole_pkg::CAPACITY))
        else $error("full status with list not full");

    // a hit never comes with a failing status
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && found_reg |-> status_reg == ole_pkg::ST_DONE)
        else $error("found set with failing status");
`endif

endmodule

/* rtl/core/ole_cell.sv */
// ole_cell: one storage cell of the list chain, with its own shift and compare logic.
// Depends on ole_pkg.

module ole_cell (
    input  logic                        aclk,
    input  logic [ole_pkg::IDX_W-1:0]   idx,
    input  ole_pkg::cell_ctrl_t         ctrl,
    input  logic [ole_pkg::DATA_W-1:0]  left_data,
    input  logic [ole_pkg::DATA_W-1:0]  right_data,
    output logic [ole_pkg::DATA_W-1:0]  data,
    output logic                        match
);

    logic [ole_pkg::DATA_W-1:0] data_reg;
    logic [ole_pkg::DATA_W-1:0] data_next;

    // insert: take the new value at the slot, shift right behind it
    // remove: shift left from the slot onward
    always_comb begin
        data_next = data_reg;
        if (ctrl.ins_en) begin
            if (idx == ctrl.slot) begin
                data_next = ctrl.value;
            end else if (idx > ctrl.slot) begin
                data_next = left_data;
            end
        end else if (ctrl.rem_en) begin
            if (idx >= ctrl.slot) begin
                data_next = right_data;
            end
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    // hit only on an occupied cell
    assign match = ({1'b0, idx} < ctrl.count) && (data_reg == ctrl.value);
    assign data  = data_reg;

endmodule

/* rtl/core/ole_chain.sv */
// ole_chain: the row of list cells, each wired to its neighbours, plus read select
// and the search hit reduction. Depends on ole_pkg and ole_cell.

module ole_chain (
    input  logic                        aclk,
    input  ole_pkg::cell_ctrl_t         ctrl,
    input  logic [ole_pkg::IDX_W-1:0]   read_slot,
    output logic [ole_pkg::DATA_W-1:0]  read_data,
    output logic                        any_match
);

    logic [ole_pkg::DATA_W-1:0] cell_q [ole_pkg::CAPACITY];
    logic [ole_pkg::DATA_W-1:0] left_d [ole_pkg::CAPACITY];
    logic [ole_pkg::DATA_W-1:0] right_d [ole_pkg::CAPACITY];
    logic [ole_pkg::CAPACITY-1:0] match_vec;

    genvar i;
    generate
        for (i = 0; i < ole_pkg::CAPACITY; i++) begin : g_cell
            // neighbour links, ends fed back from themselves
            if (i == 0) begin : g_first
                assign left_d[i] = cell_q[i];
            end else begin : g_left
                assign left_d[i] = cell_q[i-1];
            end
            if (i == ole_pkg::CAPACITY - 1) begin : g_last
                assign right_d[i] = cell_q[i];
            end else begin : g_right
                assign right_d[i] = cell_q[i+1];
            end

            ole_cell u_cell (
                .aclk       (aclk),
                .idx        (ole_pkg::IDX_W'(i)),
                .ctrl       (ctrl),
                .left_data  (left_d[i]),
                .right_data (right_d[i]),
                .data       (cell_q[i]),
                .match      (match_vec[i])
            );
        end
    endgenerate

    // read port and search result
    assign read_data = cell_q[read_slot];
    assign any_match = |match_vec;

endmodule

/* tb/tb_ordered_list_engine.sv */
// tb_ordered_list_engine: self-checking bench for the ordered list engine. It sends command
// requests, predicts each result from its own copy of the list or takes it from the directed
// rows, and compares field by field. Depends on ole_pkg and ordered_list_engine from rtl/core.

module tb_ordered_list_engine;

    localparam int CLK_HALF     = 5;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_ITEMS   = 2000;
    localparam int BLOCK_ITEMS  = 40;
    localparam int QUIET_ITEMS  = 400;
    localparam int MAX_REPORTS  = 100;
    localparam int RESULT_SLOTS = 4096;
    localparam int ROW_SLOTS    = 64;

    localparam logic [ole_pkg::DATA_W-1:0] MOST_NEG = {1'b1, {(ole_pkg::DATA_W-1){1'b0}}};
    localparam logic [ole_pkg::DATA_W-1:0] MOST_POS = {1'b0, {(ole_pkg::DATA_W-1){1'b1}}};
    localparam logic [ole_pkg::DATA_W-1:0] ALL_ONES = {ole_pkg::DATA_W{1'b1}};

    typedef struct {
        logic [ole_pkg::STATUS_W-1:0] status;
        logic [ole_pkg::DATA_W-1:0]   read_value;
        logic                         found;
        logic [ole_pkg::COUNT_W-1:0]  count;
    } list_result_t;

    typedef struct {
        logic [ole_pkg::OP_W-1:0]   op;
        logic [ole_pkg::POS_W-1:0]  pos;
        logic [ole_pkg::DATA_W-1:0] value;
        int                         reps;
        bit                         known;
        list_result_t               want;
    } cmd_row_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ole_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ole_pkg::OUT_TDATA_W-1:0] m_tdata;

    // bench copy of the list, front at index 0
    logic [ole_pkg::DATA_W-1:0] shadow_cells [ole_pkg::CAPACITY];
    int unsigned                shadow_len = 0;

    // expected results in a ring, written by the sender and read by the checker
    list_result_t awaited_results [RESULT_SLOTS];
    int unsigned  awaited_wr      = 0;
    int unsigned  awaited_rd      = 0;
    cmd_row_t     directed_rows [ROW_SLOTS];
    int           row_total       = 0;
    int unsigned  mismatches      = 0;
    int unsigned  cycle_count     = 0;
    bit           src_idle_on     = 1'b0;
    bit           sink_idle_on    = 1'b0;
    int           sink_stall_left = 0;

    always #CLK_HALF aclk = ~aclk;

    ordered_list_engine u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // applies one command to the bench list and returns the result it should give
    function automatic list_result_t apply_command(input logic [ole_pkg::OP_W-1:0] op,
            input logic [ole_pkg::POS_W-1:0] pos, input logic [ole_pkg::DATA_W-1:0] value);
        list_result_t res;
        int unsigned  slot;
        int unsigned  i;
        res.status     = ole_pkg::ST_DONE;
        res.read_value = '0;
        res.found      = 1'b0;
        slot           = 0;
        case (op)
            ole_pkg::OP_PUSH_FRONT, ole_pkg::OP_PUSH_BACK, ole_pkg::OP_INSERT: begin
                // an insert checks its slot before fullness
                if (op == ole_pkg::OP_INSERT && pos > shadow_len) begin
                    res.status = ole_pkg::ST_RANGE;
                end else if (shadow_len >= ole_pkg::CAPACITY) begin
                    res.status = ole_pkg::ST_FULL;
                end else begin
                    if (op == ole_pkg::OP_PUSH_BACK)
                        slot = shadow_len;
                    else if (op == ole_pkg::OP_INSERT)
                        slot = pos;
                    for (i = shadow_len; i > slot; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[slot] = value;
                    shadow_len++;
                end
            end
            ole_pkg::OP_POP_FRONT, ole_pkg::OP_POP_BACK, ole_pkg::OP_REMOVE: begin
                // a remove on an empty list is a range fault, not an empty one
                if (op == ole_pkg::OP_REMOVE && (pos == 0 || pos > shadow_len)) begin
                    res.status = ole_pkg::ST_RANGE;
                end else if (shadow_len == 0) begin
                    res.status = ole_pkg::ST_EMPTY;
                end else begin
                    if (op == ole_pkg::OP_POP_BACK)
                        slot = shadow_len - 1;
                    else if (op == ole_pkg::OP_REMOVE)
                        slot = pos - 1;
                    for (i = slot; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end
            end
            ole_pkg::OP_READ: begin
                if (pos == 0 || pos > shadow_len)
                    res.status = ole_pkg::ST_RANGE;
                else
                    res.read_value = shadow_cells[pos-1];
            end
            default: begin
                for (i = 0; i < shadow_len; i++)
                    if (shadow_cells[i] == value)
                        res.found = 1'b1;
            end
        endcase
        res.count = ole_pkg::COUNT_W'(shadow_len);
        return res;
    endfunction

    function automatic void flag_mismatch(input string field,
            input logic [ole_pkg::DATA_W-1:0] want, input logic [ole_pkg::DATA_W-1:0] got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endfunction

    // appends one expected result to the ring
    function automatic void book_result(input list_result_t res);
        awaited_results[awaited_wr & (RESULT_SLOTS - 1)] = res;
        awaited_wr++;
    endfunction

    task automatic add_row(input logic [ole_pkg::OP_W-1:0] op, input int pos,
            input logic [ole_pkg::DATA_W-1:0] value, input int reps, input bit known,
            input logic [ole_pkg::STATUS_W-1:0] status, input logic [ole_pkg::DATA_W-1:0] rd,
            input bit found, input int count);
        cmd_row_t row;
        row.op              = op;
        row.pos             = ole_pkg::POS_W'(pos);
        row.value           = value;
        row.reps            = reps;
        row.known           = known;
        row.want.status     = status;
        row.want.read_value = rd;
        row.want.found      = found;
        row.want.count      = ole_pkg::COUNT_W'(count);
        directed_rows[row_total] = row;
        row_total++;
    endtask

    // offers one request, waits for it to be taken, then books its result
    task automatic send_cmd(input logic [ole_pkg::OP_W-1:0] op,
            input logic [ole_pkg::POS_W-1:0] pos, input logic [ole_pkg::DATA_W-1:0] value,
            input bit known, input list_result_t want);
        list_result_t predicted;
        if (src_idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {value, pos, op};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_command(op, pos, value);
        if (known)
            book_result(want);
        else
            book_result(predicted);
    endtask

    // random request; grow mode favours additions, shrink mode favours removals
    task automatic send_random(input int mode);
        logic [ole_pkg::OP_W-1:0]   op;
        logic [ole_pkg::POS_W-1:0]  pos;
        logic [ole_pkg::DATA_W-1:0] value;
        int unsigned                pick;
        int unsigned                add_share;
        int unsigned                del_share;
        list_result_t               none;
        add_share = (mode == 0) ? 70 : (mode == 1) ? 15 : 40;
        del_share = (mode == 0) ? 15 : (mode == 1) ? 60 : 35;
        pick = $urandom_range(0, 99);
        if (pick < add_share) begin
            case ($urandom_range(0, 2))
                0:       op = ole_pkg::OP_PUSH_FRONT;
                1:       op = ole_pkg::OP_PUSH_BACK;
                default: op = ole_pkg::OP_INSERT;
            endcase
        end else if (pick < add_share + del_share) begin
            case ($urandom_range(0, 2))
                0:       op = ole_pkg::OP_POP_FRONT;
                1:       op = ole_pkg::OP_POP_BACK;
                default: op = ole_pkg::OP_REMOVE;
            endcase
        end else begin
            op = $urandom_range(0, 1) ? ole_pkg::OP_READ : ole_pkg::OP_FIND;
        end

        // mostly legal positions, now and then anything the field holds
        case (op)
            ole_pkg::OP_INSERT: begin
                if ($urandom_range(0, 9) != 0)
                    pos = ole_pkg::POS_W'($urandom_range(0, shadow_len));
                else
                    pos = ole_pkg::POS_W'($urandom_range(0, 31));
            end
            ole_pkg::OP_REMOVE, ole_pkg::OP_READ: begin
                if (shadow_len != 0 && $urandom_range(0, 9) != 0)
                    pos = ole_pkg::POS_W'($urandom_range(1, shadow_len));
                else
                    pos = ole_pkg::POS_W'($urandom_range(0, 31));
            end
            default: pos = ole_pkg::POS_W'($urandom_range(0, 31));
        endcase

        // finds mostly look for something stored
        pick = $urandom_range(0, 19);
        if (op == ole_pkg::OP_FIND && shadow_len != 0 && pick < 12) begin
            value = shadow_cells[$urandom_range(0, shadow_len - 1)];
        end else if (pick >= 18) begin
            case ($urandom_range(0, 3))
                0:       value = '0;
                1:       value = MOST_NEG;
                2:       value = MOST_POS;
                default: value = ALL_ONES;
            endcase
        end else begin
            value = ole_pkg::DATA_W'($urandom);
        end
        send_cmd(op, pos, value, 1'b0, none);
    endtask

    // result checker: status [1:0], read_value [33:2], found [34], count [39:35]
    always @(posedge aclk) begin : check_results
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_wr == awaited_rd) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with none expected, actual %h", $time, m_tdata);
            end else begin
                want = awaited_results[awaited_rd & (RESULT_SLOTS - 1)];
                awaited_rd++;
                if (m_tdata[1:0] !== want.status)
                    flag_mismatch("status", want.status, m_tdata[1:0]);
                if (m_tdata[33:2] !== want.read_value)
                    flag_mismatch("read_value", want.read_value, m_tdata[33:2]);
                if (m_tdata[34] !== want.found)
                    flag_mismatch("found", want.found, m_tdata[34]);
                if (m_tdata[39:35] !== want.count)
                    flag_mismatch("count", want.count, m_tdata[39:35]);
            end
        end
    end

    // sink back-pressure in random bursts while sink idling is on
    always @(posedge aclk) begin
        if (!sink_idle_on) begin
            sink_stall_left <= 0;
            m_tready        <= 1'b1;
        end else if (sink_stall_left > 0) begin
            sink_stall_left <= sink_stall_left - 1;
            m_tready        <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            sink_stall_left <= $urandom_range(0, 16);
            m_tready        <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     awaited_wr - awaited_rd);
            $display("FAIL ordered_list_engine");
            $finish;
        end
    end

    initial begin
        cmd_row_t                   row;
        int                         n;
        int                         mode;
        logic [ole_pkg::DATA_W-1:0] value;

        // empty list: pops, bad positions, find
        add_row(ole_pkg::OP_POP_FRONT,   0, '0,       1, 1, ole_pkg::ST_EMPTY, '0, 0, 0);
        add_row(ole_pkg::OP_POP_BACK,   31, '0,       1, 1, ole_pkg::ST_EMPTY, '0, 0, 0);
        add_row(ole_pkg::OP_REMOVE,      1, '0,       1, 1, ole_pkg::ST_RANGE, '0, 0, 0);
        add_row(ole_pkg::OP_READ,        0, '0,       1, 1, ole_pkg::ST_RANGE, '0, 0, 0);
        add_row(ole_pkg::OP_FIND,        0, '0,       1, 1, ole_pkg::ST_DONE,  '0, 0, 0);
        add_row(ole_pkg::OP_INSERT,      1, 32'd5,    1, 1, ole_pkg::ST_RANGE, '0, 0, 0);
        // extreme values at both ends, then read and find them and remove one
        add_row(ole_pkg::OP_INSERT,      0, MOST_NEG, 1, 1, ole_pkg::ST_DONE,  '0, 0, 1);
        add_row(ole_pkg::OP_PUSH_BACK,   0, MOST_POS, 1, 1, ole_pkg::ST_DONE,  '0, 0, 2);
        add_row(ole_pkg::OP_PUSH_FRONT,  0, ALL_ONES, 1, 1, ole_pkg::ST_DONE,  '0, 0, 3);
        add_row(ole_pkg::OP_READ,    1, '0, 1, 1, ole_pkg::ST_DONE, ALL_ONES, 0, 3);
        add_row(ole_pkg::OP_READ,    3, '0, 1, 1, ole_pkg::ST_DONE, MOST_POS, 0, 3);
        add_row(ole_pkg::OP_FIND,        0, MOST_NEG, 1, 1, ole_pkg::ST_DONE,  '0, 1, 3);
        add_row(ole_pkg::OP_REMOVE,      0, '0,       1, 1, ole_pkg::ST_RANGE, '0, 0, 3);
        add_row(ole_pkg::OP_REMOVE,      2, '0,       1, 1, ole_pkg::ST_DONE,  '0, 0, 2);
        add_row(ole_pkg::OP_INSERT,      1, '0,       1, 1, ole_pkg::ST_DONE,  '0, 0, 3);
        // fill up with random values (value column unused when repeated)
        add_row(ole_pkg::OP_PUSH_BACK,   0, '0,      13, 0, ole_pkg::ST_DONE,  '0, 0, 0);
        // full list, then remove and pop from it
        add_row(ole_pkg::OP_PUSH_BACK,   0, '0,       1, 1, ole_pkg::ST_FULL,  '0, 0, 16);
        add_row(ole_pkg::OP_PUSH_FRONT,  0, '0,       1, 1, ole_pkg::ST_FULL,  '0, 0, 16);
        add_row(ole_pkg::OP_INSERT,     17, '0,       1, 1, ole_pkg::ST_RANGE, '0, 0, 16);
        add_row(ole_pkg::OP_INSERT,     16, '0,       1, 1, ole_pkg::ST_FULL,  '0, 0, 16);
        add_row(ole_pkg::OP_READ,       16, '0,       1, 0, ole_pkg::ST_DONE,  '0, 0, 0);
        add_row(ole_pkg::OP_READ,       31, '0,       1, 1, ole_pkg::ST_RANGE, '0, 0, 16);
        add_row(ole_pkg::OP_FIND,        0, ALL_ONES, 1, 1, ole_pkg::ST_DONE,  '0, 1, 16);
        add_row(ole_pkg::OP_REMOVE,     16, '0,       1, 1, ole_pkg::ST_DONE,  '0, 0, 15);
        add_row(ole_pkg::OP_POP_FRONT,   0, '0,       1, 1, ole_pkg::ST_DONE,  '0, 0, 14);
        add_row(ole_pkg::OP_POP_BACK,    0, '0,       1, 1, ole_pkg::ST_DONE,  '0, 0, 13);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        for (int r = 0; r < row_total; r++) begin
            row = directed_rows[r];
            for (n = 0; n < row.reps; n++) begin
                value = (row.reps > 1) ? ole_pkg::DATA_W'($urandom) : row.value;
                send_cmd(row.op, row.pos, value, row.known, row.want);
            end
        end

        // random requests in blocks, each with its own mix and idling; quiet tail
        mode = 0;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0) begin
                mode         = $urandom_range(0, 2);
                src_idle_on  = (n < RAND_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
                sink_idle_on = (n < RAND_ITEMS - QUIET_ITEMS) && ($urandom_range(0, 3) != 0);
            end
            send_random(mode);
        end
        s_tvalid <= 1'b0;

        // drain, then wait for anything stray
        while (awaited_wr != awaited_rd) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("PASS ordered_list_engine");
        else
            $display("FAIL ordered_list_engine");
        $finish;
    end

endmodule
